// ===== design/rlsi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and opcode constants for the run-length skip iterator.
// No dependencies.
package rlsi_pkg;

   localparam int unsigned DATA_W = 31;

   typedef logic [1:0] opcode_type;

   localparam opcode_type OP_CLEAR  = 2'd0;
   localparam opcode_type OP_APPEND = 2'd1;
   localparam opcode_type OP_SKIP   = 2'd2;

   typedef struct packed {
      opcode_type        opcode;
      logic [DATA_W-1:0] run_count;
      logic [DATA_W-1:0] run_value;
      logic [DATA_W-1:0] skip_count;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] element_value;
      logic              exhausted;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic walk;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip_req;
      logic finish;
   } ctrl_sts_type;

endpackage

// ===== design/rlsi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the run-length skip iterator.
// Depends on rlsi_pkg.
module rlsi_ctrl
   import rlsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd.accept = start && (state_ff == ST_IDLE);
      cmd.walk   = (state_ff == ST_WALK);
      busy       = (state_ff != ST_IDLE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && sts.skip_req) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (sts.finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/rlsi_dpath.sv =====
`timescale 1ns / 1ps
// Datapath for the run-length skip iterator: run stores, pointers, need counter, result.
// Depends on rlsi_pkg.
module rlsi_dpath
   import rlsi_pkg::*;
#(
   parameter int MAX_RUNS = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  ctrl_cmd_type cmd,
   output ctrl_sts_type sts,
   output rsp_type      rsp_data,
   output logic         rsp_strobe
);

   localparam int CW = $clog2(MAX_RUNS + 1);
   localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam logic [CW-1:0] DEPTH = CW'(MAX_RUNS);

   logic [DATA_W-1:0] count_mem [MAX_RUNS];
   logic [DATA_W-1:0] value_mem [MAX_RUNS];

   logic [CW-1:0]     read_index_ff, read_index_in;
   logic [CW-1:0]     run_total_ff, run_total_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [DATA_W-1:0] need_ff, need_in;
   logic [DATA_W-1:0] cnt_rd_ff, val_rd_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   logic [CW-1:0]     idx_inc;
   logic              at_end, cnt_lt;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              wr_cnt_en, wr_val_en;
   logic [DATA_W-1:0] wr_count;

   always_comb begin
      idx_inc = idx_ff + CW'(1);
      at_end  = (idx_ff >= run_total_ff);
      cnt_lt  = (cnt_rd_ff < need_ff);

      sts.skip_req = (req_data.opcode == OP_SKIP);
      sts.finish   = cmd.walk && (at_end || !cnt_lt);

      read_index_in = read_index_ff;
      run_total_in  = run_total_ff;
      idx_in        = idx_ff;
      need_in       = need_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      wr_addr       = idx_ff[AW-1:0];
      wr_cnt_en     = 1'b0;
      wr_val_en     = 1'b0;
      wr_count      = cnt_rd_ff - need_ff;

      if (cmd.accept) begin
         case (req_data.opcode)
            OP_CLEAR: begin
               read_index_in = '0;
               run_total_in  = '0;
            end
            OP_APPEND: begin
               if (run_total_ff < DEPTH) begin
                  wr_addr      = run_total_ff[AW-1:0];
                  wr_count     = req_data.run_count;
                  wr_cnt_en    = 1'b1;
                  wr_val_en    = 1'b1;
                  run_total_in = run_total_ff + CW'(1);
               end
            end
            OP_SKIP: begin
               idx_in  = read_index_ff;
               rd_addr = read_index_ff[AW-1:0];
               need_in = (req_data.skip_count == '0) ? DATA_W'(1) : req_data.skip_count;
            end
            default: ;
         endcase
      end else if (cmd.walk) begin
         if (at_end) begin
            read_index_in        = run_total_ff;
            rsp_in.element_value = '0;
            rsp_in.exhausted     = 1'b1;
            strobe_in            = 1'b1;
         end else if (cnt_lt) begin
            need_in = need_ff - cnt_rd_ff;
            idx_in  = idx_inc;
            rd_addr = idx_inc[AW-1:0];
         end else begin
            rsp_in.element_value = val_rd_ff;
            rsp_in.exhausted     = 1'b0;
            strobe_in            = 1'b1;
            if (cnt_rd_ff > need_ff) begin
               wr_cnt_en     = 1'b1;
               read_index_in = idx_ff;
            end else begin
               read_index_in = idx_inc;
            end
         end
      end
   end

   // run stores with separate read and write addresses, registered read
   always_ff @(posedge clock) begin
      if (wr_cnt_en) count_mem[wr_addr] <= wr_count;
      if (wr_val_en) value_mem[wr_addr] <= req_data.run_value;
      cnt_rd_ff <= count_mem[rd_addr];
      val_rd_ff <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff <= '0;
         run_total_ff  <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         read_index_ff <= read_index_in;
         run_total_ff  <= run_total_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      need_ff <= need_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== design/run_length_skip_iterator.sv =====
`timescale 1ns / 1ps
// Run-length skip iterator top level: controller plus datapath.
// Clear and append beats leave the block idle and give no result.
// A skip beat makes the block busy while it walks the run table: one store read per run walked past.
// The result strobe is registered and sits in the cycle after the last walk cycle, while the next beat may start.
// Synchronous reset empties the table and pointers; store contents stay undefined.
// Depends on rlsi_pkg, rlsi_ctrl, rlsi_dpath.
module run_length_skip_iterator
   import rlsi_pkg::*;
#(
   parameter int MAX_RUNS = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rlsi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   rlsi_dpath #(
      .MAX_RUNS (MAX_RUNS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

// ===== design/rlsi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the run-length skip iterator, bound to the top level.
// Depends on rlsi_pkg and run_length_skip_iterator.
module rlsi_checker
   import rlsi_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_skip_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.opcode == OP_SKIP) |=> busy)
      else $error("skip beat did not start a walk");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.opcode != OP_SKIP) |=> !busy && !rsp_strobe)
      else $error("load beat made the block busy or gave a result");

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("walk ended without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy ##1 !rsp_strobe)
      else $error("result strobe overlaps a walk or repeats");

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.exhausted |-> (rsp_data.element_value == '0))
      else $error("exhausted result carries a value");

endmodule

bind run_length_skip_iterator rlsi_checker u_rlsi_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ===== bench/rlsi_skip_check.sv =====
`timescale 1ns / 1ps
// Watches the run-length skip iterator's request and result channels, predicts each
// skip result from its own copy of the run table and compares. Depends on rlsi_pkg.
module rlsi_skip_check
   import rlsi_pkg::*;
#(
   parameter int MAX_RUNS = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

   logic [DATA_W-1:0] run_left [MAX_RUNS];
   logic [DATA_W-1:0] run_val [MAX_RUNS];
   int unsigned       cursor;
   int unsigned       loaded;
   rsp_type           landing_q[$];

   // consume n elements (zero counts as one), return the last one or the exhausted flag
   function automatic rsp_type skip_ahead(logic [DATA_W-1:0] amount);
      int unsigned need;
      int unsigned idx;
      rsp_type     r;
      need = (amount == '0) ? 1 : amount;
      idx  = cursor;
      while (idx < loaded && run_left[idx[AW-1:0]] < need) begin
         need -= run_left[idx[AW-1:0]];
         idx++;
      end
      if (idx >= loaded) begin
         cursor          = loaded;
         r.element_value = '0;
         r.exhausted     = 1'b1;
         return r;
      end
      r.element_value = run_val[idx[AW-1:0]];
      r.exhausted     = 1'b0;
      if (run_left[idx[AW-1:0]] > need)
         run_left[idx[AW-1:0]] = DATA_W'(run_left[idx[AW-1:0]] - need);
      else
         idx++;
      cursor = idx;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cursor = 0;
         loaded = 0;
         errors = 0;
         landing_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (landing_q.size() == 0) begin
               $display("%0t: result with none expected: value %h exhausted %b",
                        $time, rsp_data.element_value, rsp_data.exhausted);
               errors++;
            end else begin
               want = landing_q.pop_front();
               if (rsp_data.element_value !== want.element_value) begin
                  $display("%0t: element_value expected %h got %h",
                           $time, want.element_value, rsp_data.element_value);
                  errors++;
               end
               if (rsp_data.exhausted !== want.exhausted) begin
                  $display("%0t: exhausted expected %b got %b",
                           $time, want.exhausted, rsp_data.exhausted);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            case (req_data.opcode)
               OP_CLEAR: begin
                  cursor = 0;
                  loaded = 0;
               end
               OP_APPEND: begin
                  if (loaded < MAX_RUNS) begin
                     run_left[loaded[AW-1:0]] = req_data.run_count;
                     run_val[loaded[AW-1:0]]  = req_data.run_value;
                     loaded++;
                  end
               end
               OP_SKIP: landing_q.push_back(skip_ahead(req_data.skip_count));
               default: ;
            endcase
         end
      end
      pending = landing_q.size();
   end

endmodule

// ===== bench/run_length_skip_iterator_test.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the run-length skip iterator: directed beats, then random
// table loads and skips. Depends on rlsi_pkg, run_length_skip_iterator, rlsi_skip_check.
module run_length_skip_iterator_test;
   import rlsi_pkg::*;

   localparam opcode_type OP_UNUSED = 2'd3;
   localparam int         BEATS     = 1950;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      errors;
   int      pending;
   int      beats = 0;
   bit      quiet = 1'b0;
   bit      filled = 1'b0;

   always #5 clock = ~clock;

   run_length_skip_iterator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   rlsi_skip_check skip_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .errors     (errors),
      .pending    (pending)
   );

   function automatic logic [DATA_W-1:0] any31();
      return DATA_W'($urandom);
   endfunction

   function automatic logic [DATA_W-1:0] pick_run();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         8:       return DATA_W'($urandom_range(9, 1000));
         9:       return any31();
         default: return DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_skip();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return any31();
         2:       return DATA_W'($urandom_range(9, 60));
         default: return DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   // called at a falling edge; returns on one after the beat is taken and any idle gap
   task automatic send(opcode_type op, logic [DATA_W-1:0] cnt, logic [DATA_W-1:0] val,
                       logic [DATA_W-1:0] skip);
      req_type r;
      r.opcode     = op;
      r.run_count  = cnt;
      r.run_value  = val;
      r.skip_count = skip;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (op != OP_UNUSED)
         beats++;
      if (!quiet && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic load_and_drain(int runs);
      int skips;
      skips = $urandom_range(1, runs + 4);
      send(OP_CLEAR, any31(), any31(), any31());
      repeat (runs) send(OP_APPEND, pick_run(), any31(), any31());
      repeat (skips) begin
         if ($urandom_range(0, 9) == 0)
            send(OP_APPEND, pick_run(), any31(), any31());
         else
            send(OP_SKIP, any31(), any31(), pick_skip());
      end
   endtask

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int r;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      send(OP_SKIP, '0, '0, 31'd5);
      send(OP_UNUSED, '1, '1, '1);
      send(OP_APPEND, '0, 31'h7fff_ffff, '0);
      send(OP_APPEND, 31'd3, '0, '1);
      send(OP_APPEND, 31'h7fff_ffff, 31'h2aaa_aaaa, '0);
      send(OP_APPEND, 31'd1, 31'h5555_5555, '1);
      send(OP_SKIP, '1, '1, '0);
      send(OP_SKIP, '0, '0, 31'd2);
      send(OP_SKIP, '0, '0, 31'h7fff_fffe);
      send(OP_SKIP, '0, '0, 31'd1);
      send(OP_SKIP, '0, '0, 31'd1);
      send(OP_SKIP, '0, '0, 31'd1);
      send(OP_SKIP, '0, '0, 31'h7fff_ffff);
      send(OP_CLEAR, '0, '0, '0);
      send(OP_APPEND, 31'h7fff_ffff, 31'd5, '0);
      send(OP_APPEND, 31'h7fff_ffff, 31'd6, '0);
      send(OP_SKIP, '0, '0, 31'h7fff_ffff);
      send(OP_SKIP, '0, '0, 31'h7fff_ffff);
      send(OP_SKIP, '0, '0, 31'd1);
      send(OP_CLEAR, '1, '1, '1);
      send(OP_SKIP, '1, '1, 31'd1);

      // random
      while (beats < BEATS) begin
         quiet = (beats >= 300 && beats < 650);
         r     = $urandom_range(0, 99);
         if (!filled && beats > 900) begin
            filled = 1'b1;
            send(OP_CLEAR, any31(), any31(), any31());
            repeat (520) send(OP_APPEND, DATA_W'($urandom_range(0, 3)), any31(), any31());
            send(OP_SKIP, any31(), any31(), 31'd1);
            repeat (4) send(OP_SKIP, any31(), any31(), DATA_W'($urandom_range(50, 400)));
            send(OP_SKIP, any31(), any31(), '1);
         end else if (r < 8) begin
            send(opcode_type'($urandom_range(0, 3)), any31(), any31(), pick_skip());
         end else if (r < 15) begin
            load_and_drain($urandom_range(13, 60));
         end else begin
            load_and_drain($urandom_range(1, 12));
         end
      end

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
